// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/sprc_pkg.sv
// ----------------------------------------------------------------------------
// sprc_pkg
// Widths, codes, reset values and shared types of the stepper ramp controller.
// ----------------------------------------------------------------------------
package sprc_pkg;

	localparam int POS_W       = 32;
	localparam int RATE_W      = 16;
	localparam int TIME_W      = 32;
	localparam int CLK_W       = 32;
	localparam int CMD_W       = 3;
	localparam int APB_DW      = 32;
	localparam int REG_IDX_W   = 3;
	localparam int ADDR_W      = REG_IDX_W + 2;
	localparam int IN_TDATA_W  = 80;   // now_ms, target_position, requested_rate
	localparam int OUT_TDATA_W = 120;  // 116 bits of fields plus byte fill
	localparam int DIV_CNT_W   = $clog2(CLK_W);

	localparam logic [CLK_W-1:0] PERIOD_FLOOR = CLK_W'(4);

	// register reset values
	localparam logic signed [POS_W-1:0] RST_MIN_POS     = -32'sd20000;
	localparam logic signed [POS_W-1:0] RST_MAX_POS     = 32'sd20000;
	localparam logic [RATE_W-1:0]       RST_MIN_RATE    = 16'd100;
	localparam logic [RATE_W-1:0]       RST_MAX_RATE    = 16'd5000;
	localparam logic [RATE_W-1:0]       RST_RATE_SLEW   = 16'd50;
	localparam logic [RATE_W-1:0]       RST_WAKE_DELAY  = 16'd2;
	localparam logic                    RST_INVERT_DIR  = 1'b0;
	localparam logic [CLK_W-1:0]        RST_TIMER_CLOCK = 32'd32000000;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENABLE = 3'd0,
		CMD_DISARM = 3'd1,
		CMD_HOLD   = 3'd2,
		CMD_TARGET = 3'd3,
		CMD_RATE   = 3'd4,
		CMD_TICK   = 3'd5,
		CMD_STEP   = 3'd6
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MIN_POS     = 3'd0,
		REG_MAX_POS     = 3'd1,
		REG_MIN_RATE    = 3'd2,
		REG_MAX_RATE    = 3'd3,
		REG_RATE_SLEW   = 3'd4,
		REG_WAKE_DELAY  = 3'd5,
		REG_INVERT_DIR  = 3'd6,
		REG_TIMER_CLOCK = 3'd7
	} reg_idx_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: design/sprc_div.sv
// ----------------------------------------------------------------------------
// sprc_div
// Restoring divider, one quotient bit per cycle: timer clock over step rate.
// ----------------------------------------------------------------------------
module sprc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sprc_pkg::CLK_W-1:0]  dividend,
	input  logic [sprc_pkg::RATE_W-1:0] divisor,
	output logic [sprc_pkg::CLK_W-1:0]  quotient,
	output sprc_pkg::div_stat_t         stat
);
	import sprc_pkg::*;

	logic [CLK_W-1:0]     quo_q;
	logic [RATE_W-1:0]    rem_q;
	logic [RATE_W-1:0]    dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [RATE_W:0]      trial;
	logic [RATE_W+1:0]    diff;

	// zero divisor never restores, so the quotient comes out all ones
	assign trial = {rem_q, quo_q[CLK_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(CLK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[CLK_W-2:0], ~diff[RATE_W+1]};
			rem_q <= diff[RATE_W+1] ? trial[RATE_W-1:0] : diff[RATE_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: design/stepper_position_ramp_controller.sv
// ----------------------------------------------------------------------------
// stepper_position_ramp_controller
// Stepper position controller with step rate slew and period computation.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_ group (command in s_tuser, operands in s_tdata).
//   One status word leaves on the m_ group for every accepted command.
//   Configuration goes through the APB port, registers at byte address 4*i;
//   write only while no command is in flight.
// Sequencing (states from accept until m_tvalid goes high):
//   Enable, disarm, hold, set rate, unused code, idle tick: EXEC, DONE.
//   Set target: EXEC, CHECK, DONE; step that moves: EXEC, MOVE, DONE; tick
//   with no rate change: EXEC, SLEW, CLAMP, DONE. Tick that starts or reverses
//   the motor: EXEC, DIV, DONE; tick that changes the rate: EXEC, SLEW, CLAMP,
//   DIV, DONE. In DIV the serial divider (timer_clock / rate, one bit per cycle) runs.
//   s_tready is low from accept until the result is loaded into the output
//   register, so a new command is taken only once the last one is through.
// Stall:
//   A result waits in the output register while m_tready is low; the next
//   command may be accepted and worked, then waits to be delivered.
// Reset:
//   arst_n clears control and motion state, loads register defaults; the
//   block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stepper_position_ramp_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sprc_pkg::ADDR_W-1:0]      paddr,
	input  logic [sprc_pkg::APB_DW-1:0]      pwdata,
	output logic [sprc_pkg::APB_DW-1:0]      prdata,
	output logic                            pready,
	// command words
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [31:0] now_ms, [63:32] target_position, [79:64] requested_rate
	input  logic [sprc_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [2:0] command
	input  logic [sprc_pkg::CMD_W-1:0]       s_tuser,
	// status words
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [31:0] position, [63:32] target, [79:64] rate, [80] direction_level,
	// [81] enabled, [82] running, [83] at_limit, [115:84] period_ticks,
	// [119:116] zero
	output logic [sprc_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import sprc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHECK,
		ST_MOVE,
		ST_SLEW,
		ST_CLAMP,
		ST_DIV,
		ST_DONE
	} state_t;

	// configuration registers
	logic signed [POS_W-1:0] min_pos_q, max_pos_q;
	logic [RATE_W-1:0]       min_rate_q, max_rate_q, slew_q, wake_q;
	logic                    inv_q;
	logic [CLK_W-1:0]        tclk_q;

	// motion state
	logic signed [POS_W-1:0] cur_pos_q, goal_q;
	logic                    fwd_q, dir_q, en_q, run_q, lim_q;
	logic [RATE_W-1:0]       rate_q, wanted_q;
	logic [TIME_W-1:0]       en_time_q;
	logic [CLK_W-1:0]        period_q;

	// captured command
	cmd_t                    cmd_q;
	logic [TIME_W-1:0]       now_q;
	logic signed [POS_W-1:0] tgt_q;
	logic [RATE_W-1:0]       req_q;

	// sequencer scratch
	state_t                  state_q;
	logic signed [POS_W:0]   next_pos_q;
	logic [RATE_W-1:0]       next_rate_q;
	logic [RATE_W-1:0]       div_rate_q;
	logic                    div_start;
	logic                    out_load;
	logic                    m_valid_q;
	logic [OUT_TDATA_W-1:0]  m_tdata_q;

	logic [CLK_W-1:0]        quotient;
	div_stat_t               div_stat;

	logic                    cfg_wr;
	reg_idx_t                wr_idx, rd_idx;
	logic [TIME_W-1:0]       elapsed;
	logic                    want_fwd;
	logic signed [POS_W-1:0] tgt_clamp;
	logic [RATE_W-1:0]       slew_next, rate_gap, rate_step;
	logic                    at_limit;

	function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r,
			input logic [RATE_W-1:0] lo, input logic [RATE_W-1:0] hi);
		priority if (r < lo) return lo;
		else if (r > hi) return hi;
		else return r;
	endfunction

	// goal reached or behind in the present direction
	function automatic logic passed(input logic signed [POS_W-1:0] goal,
			input logic signed [POS_W-1:0] cur, input logic fwd);
		return fwd ? (goal <= cur) : (goal >= cur);
	endfunction

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign wr_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign rd_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pos_q  <= RST_MIN_POS;
			max_pos_q  <= RST_MAX_POS;
			min_rate_q <= RST_MIN_RATE;
			max_rate_q <= RST_MAX_RATE;
			slew_q     <= RST_RATE_SLEW;
			wake_q     <= RST_WAKE_DELAY;
			inv_q      <= RST_INVERT_DIR;
			tclk_q     <= RST_TIMER_CLOCK;
		end else if (cfg_wr) begin
			unique case (wr_idx)
				REG_MIN_POS:     min_pos_q  <= pwdata;
				REG_MAX_POS:     max_pos_q  <= pwdata;
				REG_MIN_RATE:    min_rate_q <= pwdata[RATE_W-1:0];
				REG_MAX_RATE:    max_rate_q <= pwdata[RATE_W-1:0];
				REG_RATE_SLEW:   slew_q     <= pwdata[RATE_W-1:0];
				REG_WAKE_DELAY:  wake_q     <= pwdata[RATE_W-1:0];
				REG_INVERT_DIR:  inv_q      <= pwdata[0];
				REG_TIMER_CLOCK: tclk_q     <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (rd_idx)
			REG_MIN_POS:     prdata = min_pos_q;
			REG_MAX_POS:     prdata = max_pos_q;
			REG_MIN_RATE:    prdata = {{(APB_DW-RATE_W){1'b0}}, min_rate_q};
			REG_MAX_RATE:    prdata = {{(APB_DW-RATE_W){1'b0}}, max_rate_q};
			REG_RATE_SLEW:   prdata = {{(APB_DW-RATE_W){1'b0}}, slew_q};
			REG_WAKE_DELAY:  prdata = {{(APB_DW-RATE_W){1'b0}}, wake_q};
			REG_INVERT_DIR:  prdata = {{(APB_DW-1){1'b0}}, inv_q};
			REG_TIMER_CLOCK: prdata = tclk_q;
		endcase
	end

	// ---------------------------------------------------------------- datapath
	assign elapsed   = now_q - en_time_q;   // wraps modulo 2^32
	assign want_fwd  = goal_q > cur_pos_q;
	assign tgt_clamp = (tgt_q < min_pos_q) ? min_pos_q :
	                   (tgt_q > max_pos_q) ? max_pos_q : tgt_q;

	// slew toward the requested rate, at most rate_slew per tick
	always_comb begin
		rate_gap  = (rate_q < wanted_q) ? (wanted_q - rate_q) : (rate_q - wanted_q);
		rate_step = (rate_gap > slew_q) ? slew_q : rate_gap;
		priority if (rate_q < wanted_q) slew_next = rate_q + rate_step;
		else if (rate_q > wanted_q) slew_next = rate_q - rate_step;
		else slew_next = rate_q;
	end

	assign at_limit = lim_q || (cur_pos_q <= min_pos_q) || (cur_pos_q >= max_pos_q);

	// divider kicks off in the first cycle of the wait state
	assign div_start = (state_q == ST_DIV) && !div_stat.busy && !div_stat.done;

	// status word moves into the output register
	assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_tready);

	sprc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (tclk_q),
		.divisor  (div_rate_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_pos_q   <= '0;
			goal_q      <= '0;
			fwd_q       <= 1'b1;
			rate_q      <= '0;
			wanted_q    <= RST_MIN_RATE;
			dir_q       <= 1'b0;
			en_q        <= 1'b0;
			run_q       <= 1'b0;
			lim_q       <= 1'b0;
			en_time_q   <= '0;
			period_q    <= '0;
			m_valid_q   <= 1'b0;
			cmd_q       <= CMD_ENABLE;
			now_q       <= '0;
			tgt_q       <= '0;
			req_q       <= '0;
			next_pos_q  <= '0;
			next_rate_q <= '0;
			div_rate_q  <= '0;
			m_tdata_q   <= '0;
		end else begin
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= cmd_t'(s_tuser);
						now_q   <= s_tdata[31:0];
						tgt_q   <= s_tdata[63:32];
						req_q   <= s_tdata[79:64];
						state_q <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					state_q <= ST_DONE;
					unique case (cmd_q)
						CMD_ENABLE: begin
							// already enabled: keep the original stamp
							if (!en_q) begin
								run_q     <= 1'b0;
								rate_q    <= '0;
								goal_q    <= cur_pos_q;
								en_time_q <= now_q;
								en_q      <= 1'b1;
							end
						end
						CMD_DISARM: begin
							run_q  <= 1'b0;
							rate_q <= '0;
							goal_q <= cur_pos_q;
							en_q   <= 1'b0;
						end
						CMD_HOLD: begin
							run_q  <= 1'b0;
							rate_q <= '0;
							goal_q <= cur_pos_q;
						end
						CMD_TARGET: begin
							goal_q  <= tgt_clamp;
							lim_q   <= (tgt_clamp != tgt_q);
							state_q <= ST_CHECK;
						end
						CMD_RATE: begin
							wanted_q <= clamp_rate(req_q, min_rate_q, max_rate_q);
						end
						CMD_TICK: begin
							priority if (!en_q || (elapsed < {{(TIME_W-RATE_W){1'b0}}, wake_q})) begin
								// disarmed or still asleep
							end else if (cur_pos_q == goal_q) begin
								run_q  <= 1'b0;
								rate_q <= '0;
							end else if (!run_q || (want_fwd != fwd_q)) begin
								// start or reversal: restart at min_rate, capped at max_rate
								run_q       <= 1'b0;
								rate_q      <= '0;
								fwd_q       <= want_fwd;
								dir_q       <= want_fwd ^ inv_q;
								div_rate_q  <= clamp_rate(min_rate_q, min_rate_q, max_rate_q);
								state_q     <= ST_DIV;
							end else begin
								state_q <= ST_SLEW;
							end
						end
						CMD_STEP: begin
							if (run_q) begin
								if (passed(goal_q, cur_pos_q, fwd_q)) begin
									run_q  <= 1'b0;
									rate_q <= '0;
								end else begin
									next_pos_q <= $signed({cur_pos_q[POS_W-1], cur_pos_q})
									            + (fwd_q ? 33'sd1 : -33'sd1);
									state_q    <= ST_MOVE;
								end
							end
						end
						default: begin
							// unused code: status only
						end
					endcase
				end

				ST_CHECK: begin
					if (run_q && passed(goal_q, cur_pos_q, fwd_q)) begin
						run_q  <= 1'b0;
						rate_q <= '0;
					end
					state_q <= ST_DONE;
				end

				ST_MOVE: begin
					// step past a bound is refused and pins the target
					if ((next_pos_q < $signed({min_pos_q[POS_W-1], min_pos_q})) ||
					    (next_pos_q > $signed({max_pos_q[POS_W-1], max_pos_q}))) begin
						lim_q  <= 1'b1;
						goal_q <= cur_pos_q;
						run_q  <= 1'b0;
						rate_q <= '0;
					end else begin
						cur_pos_q <= next_pos_q[POS_W-1:0];
						if (next_pos_q[POS_W-1:0] == goal_q) begin
							run_q  <= 1'b0;
							rate_q <= '0;
						end
					end
					state_q <= ST_DONE;
				end

				ST_SLEW: begin
					next_rate_q <= slew_next;
					state_q     <= ST_CLAMP;
				end

				ST_CLAMP: begin
					if (next_rate_q != rate_q) begin
						div_rate_q  <= clamp_rate(next_rate_q, min_rate_q, max_rate_q);
						state_q     <= ST_DIV;
					end else begin
						state_q <= ST_DONE;
					end
				end

				ST_DIV: begin
					if (div_stat.done) begin
						period_q <= (quotient < PERIOD_FLOOR) ? PERIOD_FLOOR : quotient;
						rate_q   <= div_rate_q;
						run_q    <= 1'b1;
						state_q  <= ST_DONE;
					end
				end

				ST_DONE: begin
					if (out_load) begin
						m_tdata_q <= {4'b0000, period_q, at_limit, run_q, en_q, dir_q,
						              rate_q, goal_q, cur_pos_q};
						state_q   <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_tdata_q;

	// ---------------------------------------------------------------- checks
	`ASSERT_ALWAYS(a_stop_clears_rate, !run_q |-> (rate_q == '0), "stopped with nonzero rate")
	`ASSERT_ALWAYS(a_div_owned, (state_q != ST_DIV) |-> !div_stat.busy, "divider busy outside wait")
	`ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "ready right after accept")

endmodule

// File: tb/sprc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprc_checker
// Watches the APB, command and status channels of the stepper ramp controller,
// tracks register writes and the motion state, and compares every status word
// field by field with the one its command should produce.
// ----------------------------------------------------------------------------
module sprc_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic                             pready,
	input  logic [sprc_pkg::ADDR_W-1:0]      paddr,
	input  logic [sprc_pkg::APB_DW-1:0]      pwdata,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [sprc_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic [sprc_pkg::CMD_W-1:0]       s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [sprc_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                               mismatches,
	output int                               in_flight
);
	import sprc_pkg::*;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic [POS_W-1:0]  target;
		logic [RATE_W-1:0] rate;
		logic              direction_level;
		logic              enabled;
		logic              running;
		logic              at_limit;
		logic [CLK_W-1:0]  period_ticks;
	} status_t;

	status_t status_due[$];

	// register copies
	logic signed [POS_W-1:0] pos_lo, pos_hi;
	logic [RATE_W-1:0]       rate_lo, rate_hi, slew, wake;
	logic                    inv_dir;
	logic [CLK_W-1:0]        tclk;

	// motion state
	logic signed [POS_W-1:0] pos, goal;
	logic                    fwd, dir, en, run, lim;
	logic [RATE_W-1:0]       rate, rate_req;
	logic [TIME_W-1:0]       t_en;
	logic [CLK_W-1:0]        period;

	task automatic reset_motion();
		pos_lo   = RST_MIN_POS;
		pos_hi   = RST_MAX_POS;
		rate_lo  = RST_MIN_RATE;
		rate_hi  = RST_MAX_RATE;
		slew     = RST_RATE_SLEW;
		wake     = RST_WAKE_DELAY;
		inv_dir  = RST_INVERT_DIR;
		tclk     = RST_TIMER_CLOCK;
		pos      = '0;
		goal     = '0;
		fwd      = 1'b1;
		dir      = 1'b0;
		en       = 1'b0;
		run      = 1'b0;
		lim      = 1'b0;
		rate     = '0;
		rate_req = RST_MIN_RATE;
		t_en     = '0;
		period   = '0;
	endtask

	task automatic write_register(input logic [REG_IDX_W-1:0] idx,
		input logic [APB_DW-1:0] v);
		case (reg_idx_t'(idx))
		REG_MIN_POS:     pos_lo = v;
		REG_MAX_POS:     pos_hi = v;
		REG_MIN_RATE:    rate_lo = v[RATE_W-1:0];
		REG_MAX_RATE:    rate_hi = v[RATE_W-1:0];
		REG_RATE_SLEW:   slew = v[RATE_W-1:0];
		REG_WAKE_DELAY:  wake = v[RATE_W-1:0];
		REG_INVERT_DIR:  inv_dir = v[0];
		REG_TIMER_CLOCK: tclk = v;
		default: ;
		endcase
	endtask

	function automatic logic signed [POS_W-1:0] clamp_position(
		input logic signed [POS_W-1:0] p);
		if (p < pos_lo)
			return pos_lo;
		if (p > pos_hi)
			return pos_hi;
		return p;
	endfunction

	function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
		if (r < rate_lo)
			return rate_lo;
		if (r > rate_hi)
			return rate_hi;
		return r;
	endfunction

	// zero rate saturates, short periods floor at PERIOD_FLOOR
	function automatic logic [CLK_W-1:0] period_of(input logic [RATE_W-1:0] r);
		logic [CLK_W-1:0] p;
		p = (r == '0) ? '1 : tclk / CLK_W'(r);
		return (p < PERIOD_FLOOR) ? PERIOD_FLOOR : p;
	endfunction

	function automatic logic target_passed();
		return fwd ? (goal <= pos) : (goal >= pos);
	endfunction

	task automatic stop_motor();
		run  = 1'b0;
		rate = '0;
	endtask

	task automatic start_motor(input logic [RATE_W-1:0] r);
		logic [RATE_W-1:0] c;
		c      = clamp_rate(r);
		period = period_of(c);
		rate   = c;
		run    = 1'b1;
	endtask

	task automatic control_tick(input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] elapsed;
		logic              want_fwd;
		logic [RATE_W-1:0] nxt, delta;
		elapsed = now - t_en;
		if (!en || elapsed < TIME_W'(wake))
			return;
		if (pos == goal) begin
			stop_motor();
			return;
		end
		want_fwd = goal > pos;
		// fresh start or reversal: restart from the lowest rate
		if (!run || want_fwd != fwd) begin
			stop_motor();
			fwd = want_fwd;
			dir = want_fwd ^ inv_dir;
			start_motor(rate_lo);
			return;
		end
		nxt = rate;
		if (nxt < rate_req) begin
			delta = rate_req - nxt;
			if (delta > slew)
				delta = slew;
			nxt = nxt + delta;
		end else if (nxt > rate_req) begin
			delta = nxt - rate_req;
			if (delta > slew)
				delta = slew;
			nxt = nxt - delta;
		end
		if (nxt != rate) begin
			nxt    = clamp_rate(nxt);
			period = period_of(nxt);
			rate   = nxt;
		end
	endtask

	task automatic step_event();
		longint nxt;
		if (!run)
			return;
		if (target_passed()) begin
			stop_motor();
			return;
		end
		nxt = longint'(pos) + (fwd ? 64'sd1 : -64'sd1);
		// step would leave the window: refuse it and park here
		if (nxt < longint'(pos_lo) || nxt > longint'(pos_hi)) begin
			lim  = 1'b1;
			goal = pos;
			stop_motor();
			return;
		end
		pos = nxt[POS_W-1:0];
		if (pos == goal)
			stop_motor();
	endtask

	task automatic run_command(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
		input logic signed [POS_W-1:0] tgt, input logic [RATE_W-1:0] req,
		output status_t st);
		logic signed [POS_W-1:0] c;
		case (cmd)
		CMD_ENABLE: if (!en) begin
			stop_motor();
			goal = pos;
			t_en = now;
			en   = 1'b1;
		end
		CMD_DISARM: begin
			stop_motor();
			goal = pos;
			en   = 1'b0;
		end
		CMD_HOLD: begin
			stop_motor();
			goal = pos;
		end
		CMD_TARGET: begin
			c    = clamp_position(tgt);
			lim  = (c != tgt);
			goal = c;
			if (run && target_passed())
				stop_motor();
		end
		CMD_RATE: rate_req = clamp_rate(req);
		CMD_TICK: control_tick(now);
		CMD_STEP: step_event();
		default: ;
		endcase
		st.position        = pos;
		st.target          = goal;
		st.rate            = rate;
		st.direction_level = dir;
		st.enabled         = en;
		st.running         = run;
		st.at_limit        = lim || pos <= pos_lo || pos >= pos_hi;
		st.period_ticks    = period;
	endtask

	function automatic int field_off(input string name, input logic signed [63:0] want,
		input logic signed [63:0] seen);
		if (want === seen)
			return 0;
		$error("%s: expected %0d, got %0d", name, want, seen);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		status_t st, want, got;
		int      bad;
		if (!arst_n) begin
			reset_motion();
			status_due.delete();
			mismatches <= 0;
			in_flight  <= 0;
		end else begin
			bad = 0;
			if (psel && penable && pwrite && pready)
				write_register(paddr[ADDR_W-1:2], pwdata);
			if (s_tvalid && s_tready) begin
				run_command(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[79:64], st);
				status_due.push_back(st);
			end
			if (m_tvalid && m_tready) begin
				got.position        = m_tdata[31:0];
				got.target          = m_tdata[63:32];
				got.rate            = m_tdata[79:64];
				got.direction_level = m_tdata[80];
				got.enabled         = m_tdata[81];
				got.running         = m_tdata[82];
				got.at_limit        = m_tdata[83];
				got.period_ticks    = m_tdata[115:84];
				if (status_due.size() == 0) begin
					$error("status word with no command waiting");
					bad++;
				end else begin
					want = status_due.pop_front();
					bad += field_off("position", 64'($signed(want.position)),
						64'($signed(got.position)));
					bad += field_off("target", 64'($signed(want.target)),
						64'($signed(got.target)));
					bad += field_off("rate", 64'(want.rate), 64'(got.rate));
					bad += field_off("direction_level", 64'(want.direction_level),
						64'(got.direction_level));
					bad += field_off("enabled", 64'(want.enabled), 64'(got.enabled));
					bad += field_off("running", 64'(want.running), 64'(got.running));
					bad += field_off("at_limit", 64'(want.at_limit), 64'(got.at_limit));
					bad += field_off("period_ticks", 64'(want.period_ticks),
						64'(got.period_ticks));
				end
			end
			mismatches <= mismatches + bad;
			in_flight  <= status_due.size();
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives commands, register writes and random back-pressure into the stepper
// ramp controller; the checker beside it predicts and compares status words.
// ----------------------------------------------------------------------------
module tb;
	import sprc_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;  // code with no meaning
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_WORDS   = 130;
	localparam longint RUN_LIMIT_NS = 5_000_000;

	logic                   clk;
	logic                   arst_n;
	logic                   psel, penable, pwrite;
	logic [ADDR_W-1:0]      paddr;
	logic [APB_DW-1:0]      pwdata;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;
	logic                   s_tvalid, s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // [31:0] now_ms, [63:32] target_position, [79:64] requested_rate
	logic [CMD_W-1:0]       s_tuser;   // [2:0] command
	logic                   m_tvalid, m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // [31:0] position ... [115:84] period_ticks

	int                mismatches, in_flight;
	bit                quiet;      // no gaps or stalls on either side
	logic [TIME_W-1:0] now_ms;     // running millisecond clock for enable/tick
	logic [RATE_W-1:0] wake_cfg;   // wake delay as last programmed

	stepper_position_ramp_controller u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sprc_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("FAIL");
		$finish;
	end

	// Status sink: a random stall before every word, none in quiet phases.
	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// One command word. Valid only drops when a gap is drawn, so a
	// back-to-back word never sees valid lowered and raised in one step.
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
		input logic signed [POS_W-1:0] tgt, input logic [RATE_W-1:0] req);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {req, tgt, now};
		do @(posedge clk); while (!s_tready);
	endtask

	// Wait until every status word is back. The extra edge first lets the
	// checker count the word accepted at the current edge.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Setup then access; psel stays up across back-to-back writes.
	task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// Register sets per phase: narrow window, full-range extremes, zero min
	// rate (saturated period) with a tiny timer clock, min rate above max
	// rate, bounds crossed over, and random sets.
	task automatic configure(input int ph);
		logic [APB_DW-1:0] v [8];
		int                i;
		case (ph)
		0: begin
			v[REG_MIN_POS]     = -32'sd8;
			v[REG_MAX_POS]     = 32'sd8;
			v[REG_MIN_RATE]    = 32'd100;
			v[REG_MAX_RATE]    = 32'd5000;
			v[REG_RATE_SLEW]   = 32'd50;
			v[REG_WAKE_DELAY]  = 32'd0;
			v[REG_INVERT_DIR]  = 32'd0;
			v[REG_TIMER_CLOCK] = 32'd32000000;
		end
		1: begin
			v[REG_MIN_POS]     = 32'h8000_0000;
			v[REG_MAX_POS]     = 32'h7FFF_FFFF;
			v[REG_MIN_RATE]    = 32'd1;
			v[REG_MAX_RATE]    = 32'd65535;
			v[REG_RATE_SLEW]   = 32'd65535;
			v[REG_WAKE_DELAY]  = 32'd65535;
			v[REG_INVERT_DIR]  = 32'd1;
			v[REG_TIMER_CLOCK] = 32'hFFFF_FFFF;
		end
		2: begin
			v[REG_MIN_POS]     = -32'sd3;
			v[REG_MAX_POS]     = 32'sd12;
			v[REG_MIN_RATE]    = 32'd0;
			v[REG_MAX_RATE]    = 32'd1;
			v[REG_RATE_SLEW]   = 32'd0;
			v[REG_WAKE_DELAY]  = 32'd3;
			v[REG_INVERT_DIR]  = 32'd0;
			v[REG_TIMER_CLOCK] = 32'd1;
		end
		3: begin
			v[REG_MIN_POS]     = 32'sd0;
			v[REG_MAX_POS]     = 32'sd20;
			v[REG_MIN_RATE]    = 32'd2000;
			v[REG_MAX_RATE]    = 32'd300;
			v[REG_RATE_SLEW]   = 32'd1000;
			v[REG_WAKE_DELAY]  = 32'd1;
			v[REG_INVERT_DIR]  = 32'd1;
			v[REG_TIMER_CLOCK] = 32'd1000000;
		end
		5: begin
			v[REG_MIN_POS]     = 32'sd6;
			v[REG_MAX_POS]     = -32'sd6;
			v[REG_MIN_RATE]    = 32'd50;
			v[REG_MAX_RATE]    = 32'd60000;
			v[REG_RATE_SLEW]   = 32'd7;
			v[REG_WAKE_DELAY]  = 32'd2;
			v[REG_INVERT_DIR]  = 32'd0;
			v[REG_TIMER_CLOCK] = 32'd12000000;
		end
		default: begin
			v[REG_MIN_POS]     = -$urandom_range(0, 40);
			v[REG_MAX_POS]     = $urandom_range(0, 40);
			v[REG_MIN_RATE]    = $urandom_range(0, 2000);
			v[REG_MAX_RATE]    = $urandom_range(1, 65535);
			v[REG_RATE_SLEW]   = $urandom_range(0, 65535);
			v[REG_WAKE_DELAY]  = $urandom_range(0, 5);
			v[REG_INVERT_DIR]  = $urandom_range(0, 1);
			v[REG_TIMER_CLOCK] = $urandom_range(1, 32'hFFFF_FFFF);
		end
		endcase
		for (i = 0; i < 8; i++)
			write_reg(reg_idx_t'(i), v[i]);
		psel    <= 1'b0;
		penable <= 1'b0;
		wake_cfg = v[REG_WAKE_DELAY][RATE_W-1:0];
	endtask

	function automatic logic signed [POS_W-1:0] pick_target();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return int'($urandom_range(0, 50)) - 25;
	endfunction

	function automatic logic [RATE_W-1:0] pick_rate();
		if ($urandom_range(0, 1) == 0)
			return RATE_W'($urandom_range(0, 65535));
		return RATE_W'($urandom_range(0, 3000));
	endfunction

	// Mostly well-formed moves (enable, rate, target, wake, then ticks, steps and a few
	// target, rate, hold, disarm words); the rest is noise with random codes and fields.
	task automatic drive_phase(input int words);
		int n, k, j, pick;
		n = 0;
		while (n < words) begin
			if ($urandom_range(0, 99) < 15) begin
				send_word(CMD_W'($urandom_range(0, 7)), $urandom, $urandom,
					RATE_W'($urandom_range(0, 65535)));
				n++;
			end else begin
				send_word(CMD_ENABLE, now_ms, $urandom, RATE_W'($urandom_range(0, 65535)));
				send_word(CMD_RATE, $urandom, $urandom, pick_rate());
				send_word(CMD_TARGET, $urandom, pick_target(),
					RATE_W'($urandom_range(0, 65535)));
				n += 3;
				// usually wait out the wake delay, sometimes stop short of it
				if ($urandom_range(0, 4) == 0)
					now_ms += $urandom_range(0, wake_cfg);
				else
					now_ms += wake_cfg + $urandom_range(0, 2);
				k = $urandom_range(6, 30);
				for (j = 0; j < k; j++) begin
					pick = $urandom_range(0, 99);
					if (pick < 40) begin
						now_ms += $urandom_range(0, 2);
						send_word(CMD_TICK, now_ms, $urandom,
							RATE_W'($urandom_range(0, 65535)));
					end else if (pick < 85)
						send_word(CMD_STEP, $urandom, $urandom,
							RATE_W'($urandom_range(0, 65535)));
					else if (pick < 91)
						send_word(CMD_TARGET, $urandom, pick_target(),
							RATE_W'($urandom_range(0, 65535)));
					else if (pick < 95)
						send_word(CMD_RATE, $urandom, $urandom, pick_rate());
					else if (pick < 98)
						send_word(CMD_HOLD, $urandom, $urandom,
							RATE_W'($urandom_range(0, 65535)));
					else
						send_word(CMD_DISARM, $urandom, $urandom,
							RATE_W'($urandom_range(0, 65535)));
					n++;
				end
			end
		end
	endtask

	initial begin
		int ph;
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		quiet    = 1'b0;
		now_ms   = 32'd1000;
		wake_cfg = RST_WAKE_DELAY;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset register values (wake delay 2 ms).
		send_word(CMD_SPARE, '1, '1, '1);                 // unused code: status only
		send_word(CMD_STEP, '0, '0, '0);                  // step while stopped
		send_word(CMD_TICK, 32'd50, '0, '0);              // tick while disarmed
		send_word(CMD_ENABLE, 32'd100, '0, '0);
		send_word(CMD_ENABLE, 32'd500, '0, '0);           // already on: time kept
		send_word(CMD_TARGET, '0, 32'sh7FFF_FFFF, '0);    // clamped high, limit flag
		send_word(CMD_TARGET, '0, 32'sh8000_0000, '0);    // clamped low
		send_word(CMD_TARGET, '0, 32'sd3, '0);
		send_word(CMD_TICK, 32'd101, '0, '0);             // still waking
		send_word(CMD_RATE, '0, '0, 16'd0);               // below min rate
		send_word(CMD_RATE, '0, '0, 16'hFFFF);            // above max rate
		send_word(CMD_TICK, 32'd102, '0, '0);             // start at min rate
		send_word(CMD_TICK, 32'd103, '0, '0);             // slew up
		repeat (3) send_word(CMD_STEP, '0, '0, '0);       // reach the target
		send_word(CMD_TICK, 32'd104, '0, '0);             // at target: stays stopped
		send_word(CMD_TARGET, '0, -32'sd2, '0);
		send_word(CMD_TICK, 32'd105, '0, '0);             // start backward
		send_word(CMD_STEP, '0, '0, '0);
		send_word(CMD_TARGET, '0, 32'sd5, '0);            // behind us while running
		send_word(CMD_HOLD, '0, '0, '0);
		send_word(CMD_DISARM, '0, '0, '0);
		send_word(CMD_ENABLE, 32'hFFFF_FFFF, '0, '0);
		send_word(CMD_TARGET, '0, 32'sd4, '0);
		send_word(CMD_TICK, 32'd0, '0, '0);               // wrapped, 1 ms elapsed
		send_word(CMD_TICK, 32'd1, '0, '0);               // wrapped, 2 ms: go
		send_word(CMD_STEP, '0, '0, '0);
		settle();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			configure(ph);
			quiet = (ph % 3 == 2);
			drive_phase(PHASE_WORDS);
			settle();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/sprc_pkg.sv
design/sprc_div.sv
design/stepper_position_ramp_controller.sv
tb/sprc_checker.sv
tb/tb.sv
